>>> sv/efd_pkg.sv
// shared types and constants for the escaped frame deframer
// no dependencies; imported by every module of the block but efd_ram
package efd_pkg;

  // default payload buffer size in bytes (one bank)
  localparam int FRAME_BYTES_DEF = 64;
  // byte count width, covers a full buffer of up to 127 bytes
  localparam int CNT_W = 7;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 8'd1;

  // register reset values
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'h48;
  localparam logic [BYTE_W-1:0] START_RST  = 8'h10;

  // one finished frame waiting for replay
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
  } desc_t;

  // back part hands a bank back to the front part
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

>>> sv/escaped_frame_deframer_top.sv
// top level of the escaped frame deframer
// depends on efd_pkg, efd_ram, efd_front, efd_queue, efd_back
//
// channel  direction  handshake         payload
// cfg      in         cfg_valid/ready   cfg_index, cfg_data
// in       in         in_valid/stall    in_rx_byte
// out      out        out_valid/stall   out_payload_byte, out_frame_end
//
// one input byte per cycle unless stalled; the parser writes one byte a cycle
// into a two-bank buffer. a closed frame of n bytes replays at one byte per
// cycle while out_stall is low. input stalls only while the bank to be
// filled is still queued or replaying (two frames outstanding).
// reset is synchronous, active low; no clearing pass is needed.
module escaped_frame_deframer_top
  import efd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_payload_byte,
  output logic                 out_frame_end
);

  localparam int IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  logic              wr_en, rd_en, push, pop, head_valid;
  logic [IDX_W:0]    wr_addr, rd_addr;
  logic [BYTE_W-1:0] wr_data, rd_data;
  desc_t             push_desc, head;
  release_t          rel;

  // config is always taken
  assign cfg_ready = 1'b1;

  efd_front #(.FRAME_BYTES(FRAME_BYTES), .IDX_W(IDX_W)) u_front (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_rx_byte,
    .wr_en, .wr_addr, .wr_data, .push, .push_desc, .rel
  );

  // two banks of frame storage
  efd_ram #(.WIDTH(BYTE_W), .DEPTH(2 ** (IDX_W + 1))) u_ram (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .re(rd_en), .raddr(rd_addr), .rdata(rd_data)
  );

  efd_queue u_queue (
    .clk, .rst_n, .push, .push_desc, .pop, .head_valid, .head
  );

  efd_back #(.FRAME_BYTES(FRAME_BYTES), .IDX_W(IDX_W)) u_back (
    .clk, .rst_n, .head_valid, .head, .pop, .rel,
    .rd_en, .rd_addr, .rd_data,
    .out_valid, .out_stall, .out_payload_byte, .out_frame_end
  );

endmodule

>>> sv/efd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module efd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/efd_front.sv
// front part: config registers, escape parser, payload write into banked buffer
// depends on efd_pkg
module efd_front
  import efd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  output logic                 wr_en,
  output logic [IDX_W:0]       wr_addr,
  output logic [BYTE_W-1:0]    wr_data,
  output logic                 push,
  output desc_t                push_desc,
  input  release_t             rel
);

  localparam logic [1:0] MODE_HUNT      = 2'd0;
  localparam logic [1:0] MODE_HUNT_ESC  = 2'd1;
  localparam logic [1:0] MODE_FRAME     = 2'd2;
  localparam logic [1:0] MODE_FRAME_ESC = 2'd3;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_BYTES);

  logic [BYTE_W-1:0] escape_r, start_r;
  logic [1:0]        mode_r, mode_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              bank_r, bank_nxt;
  logic [1:0]        busy_r, busy_nxt;
  logic              accept, is_esc, is_start, append, close;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r <= ESCAPE_RST;
      start_r  <= START_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ESCAPE) escape_r <= cfg_data;
      if (cfg_index == REG_START)  start_r  <= cfg_data;
    end
  end

  // hold input while the bank being filled is still queued or replaying
  assign in_stall = busy_r[bank_r];
  assign accept   = in_valid && !in_stall;
  assign is_esc   = (in_rx_byte == escape_r);
  assign is_start = (in_rx_byte == start_r);

  // parser
  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    append    = 1'b0;
    close     = 1'b0;
    if (accept) begin
      case (mode_r)
        MODE_HUNT: begin
          if (is_esc) mode_nxt = MODE_HUNT_ESC;
        end
        MODE_HUNT_ESC: begin
          if (is_start) begin
            count_nxt = '0;
            mode_nxt  = MODE_FRAME;
          end else begin
            mode_nxt = MODE_HUNT;
          end
        end
        MODE_FRAME: begin
          if (is_esc) mode_nxt = MODE_FRAME_ESC;
          else        append   = 1'b1;
        end
        MODE_FRAME_ESC: begin
          if (is_start) begin
            close     = 1'b1;
            count_nxt = '0;
            mode_nxt  = MODE_HUNT;
          end else if (is_esc) begin
            append = 1'b1;
          end else begin
            count_nxt = '0;
            mode_nxt  = MODE_HUNT;
          end
        end
        default: mode_nxt = MODE_HUNT;
      endcase
      // append with overflow check
      if (append) begin
        if (count_r >= FULL_CNT) begin
          count_nxt = '0;
          mode_nxt  = MODE_HUNT;
        end else begin
          count_nxt = count_r + 1'b1;
          mode_nxt  = MODE_FRAME;
        end
      end
    end
  end

  assign wr_en   = append && (count_r < FULL_CNT);
  assign wr_addr = {bank_r, count_r[IDX_W-1:0]};
  assign wr_data = in_rx_byte;

  // hand a non-empty frame to the back part
  assign push            = close && (count_r != '0);
  assign push_desc.bank  = bank_r;
  assign push_desc.count = count_r;

  // bank ownership
  always_comb begin
    busy_nxt = busy_r;
    bank_nxt = bank_r;
    if (rel.valid) busy_nxt[rel.bank] = 1'b0;
    if (push) begin
      busy_nxt[bank_r] = 1'b1;
      bank_nxt         = !bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_HUNT;
      count_r <= '0;
      bank_r  <= 1'b0;
      busy_r  <= '0;
    end else begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      bank_r  <= bank_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

>>> sv/efd_queue.sv
// two-entry queue of finished frame descriptors between front and back
// depends on efd_pkg
module efd_queue
  import efd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output logic  head_valid,
  output desc_t head
);

  desc_t      q_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] fill_r;

  // storage, no full check: two banks bound the number of entries
  always_ff @(posedge clk) begin
    if (push) q_r[wptr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= '0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head_valid = (fill_r != '0);
  assign head       = q_r[rptr_r];

endmodule

>>> sv/efd_back.sv
// back part: replays a queued frame from the buffer through an output register
// depends on efd_pkg
module efd_back
  import efd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  desc_t             head,
  output logic              pop,
  output release_t          rel,
  output logic              rd_en,
  output logic [IDX_W:0]    rd_addr,
  input  logic [BYTE_W-1:0] rd_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_payload_byte,
  output logic              out_frame_end
);

  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              p1_r, p1_nxt, p1_last_r;
  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r;
  logic              oe_r;
  logic              move1, last;

  // ram data stage advances into the output register when it is free
  assign move1 = p1_r && (!ov_r || !out_stall);
  assign rd_en = head_valid && (!p1_r || move1);
  assign last  = (idx_r + 1'b1) == head.count;

  assign rd_addr   = {head.bank, idx_r[IDX_W-1:0]};
  assign pop       = rd_en && last;
  assign rel.valid = pop;
  assign rel.bank  = head.bank;

  // read index and stage valids
  always_comb begin
    idx_nxt = idx_r;
    if (rd_en) idx_nxt = last ? '0 : idx_r + 1'b1;
    p1_nxt = rd_en || (p1_r && !move1);
    ov_nxt = move1 || (ov_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      p1_r  <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      p1_r  <= p1_nxt;
      ov_r  <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rd_en) p1_last_r <= last;
    if (move1) begin
      ob_r <= rd_data;
      oe_r <= p1_last_r;
    end
  end

  assign out_valid        = ov_r;
  assign out_payload_byte = ob_r;
  assign out_frame_end    = oe_r;

endmodule

>>> verif/tb_top.sv
// self-checking testbench for escaped_frame_deframer_top: random byte streams
// with framed payloads, checked against a cycle-free predictor of the parser
// depends on efd_pkg and the escaped frame deframer rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import efd_pkg::*;

  localparam int FRAME_BYTES = FRAME_BYTES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {HUNT, HUNT_ESC, IN_FRAME, FRAME_ESC} parse_mode_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } payload_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [BYTE_W-1:0]    out_payload_byte;
  logic                 out_frame_end;

  // predictor state and register copies
  parse_mode_t       mode = HUNT;
  logic [BYTE_W-1:0] frame_buf [FRAME_BYTES];
  int                buf_count = 0;
  logic [BYTE_W-1:0] cur_escape = ESCAPE_RST;
  logic [BYTE_W-1:0] cur_start = START_RST;

  payload_t          due_bytes_q[$];
  logic [BYTE_W-1:0] link_bytes_q[$];
  int                sent_cnt = 0;
  int                taken_cnt = 0;
  int                fail_cnt = 0;
  int                cycle_cnt = 0;
  bit                in_taken = 1'b0;
  bit                calm = 1'b0;
  int                gap_left = 0;
  int                stall_left = 0;

  escaped_frame_deframer_top #(
    .FRAME_BYTES(FRAME_BYTES)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_payload_byte(out_payload_byte),
    .out_frame_end   (out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // payload byte into the buffer, overflow drops the frame
  function automatic void store_byte(input logic [BYTE_W-1:0] b);
    if (buf_count >= FRAME_BYTES) begin
      buf_count = 0;
      mode = HUNT;
    end else begin
      frame_buf[buf_count] = b;
      buf_count++;
      mode = IN_FRAME;
    end
  endfunction

  // parser step: one link byte in, closing pair queues the whole frame
  function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
    payload_t p;
    case (mode)
      HUNT: begin
        if (b == cur_escape) mode = HUNT_ESC;
      end
      HUNT_ESC: begin
        if (b == cur_start) begin
          buf_count = 0;
          mode = IN_FRAME;
        end else begin
          mode = HUNT;
        end
      end
      IN_FRAME: begin
        if (b == cur_escape) mode = FRAME_ESC;
        else store_byte(b);
      end
      default: begin
        // start test comes first, so equal codes close the frame
        if (b == cur_start) begin
          for (int i = 0; i < buf_count; i++) begin
            p.data = frame_buf[i];
            p.last = (i == buf_count - 1);
            due_bytes_q.push_back(p);
          end
          buf_count = 0;
          mode = HUNT;
        end else if (b == cur_escape) begin
          store_byte(b);
        end else begin
          buf_count = 0;
          mode = HUNT;
        end
      end
    endcase
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_idle();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(0, 12);
    if (r < 93) return $urandom_range(13, 40);
    return $urandom_range(62, 66);
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    link_bytes_q.push_back(b);
    sent_cnt++;
  endtask

  // one frame with random payload, mostly closed, sometimes broken
  task automatic build_frame(input int len);
    logic [BYTE_W-1:0] b;
    int                r;
    send_byte(cur_escape);
    send_byte(cur_start);
    for (int i = 0; i < len; i++) begin
      b = BYTE_W'($urandom_range(255));
      if (b == cur_escape) begin
        if (cur_escape == cur_start) b = b ^ 8'h01;
        else send_byte(cur_escape);
      end
      send_byte(b);
    end
    r = $urandom_range(99);
    if (r < 75) begin
      send_byte(cur_escape);
      send_byte(cur_start);
    end else if (r < 88) begin
      do b = BYTE_W'($urandom_range(255));
      while (b == cur_escape || b == cur_start);
      send_byte(cur_escape);
      send_byte(b);
    end
    // line noise between frames
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input int budget);
    int target;
    target = sent_cnt + budget;
    while (sent_cnt < target) build_frame(pick_len());
  endtask

  // all bytes taken and every payload byte seen, then let the back part settle
  task automatic wait_idle();
    while (taken_cnt != sent_cnt || due_bytes_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_ESCAPE) cur_escape = val;
    else if (idx == REG_START) cur_start = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // input driver, one request per accepted byte
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (link_bytes_q.size() != 0) begin
        in_rx_byte <= link_bytes_q.pop_front();
        in_valid   <= 1'b1;
        gap_left = pick_idle();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_idle();
    end
  end

  // monitor: check results, then feed accepted bytes to the predictor
  always @(posedge clk) begin
    payload_t p;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (due_bytes_q.size() == 0) begin
          $error("unexpected payload byte %h frame_end %b", out_payload_byte, out_frame_end);
          fail_cnt++;
        end else begin
          p = due_bytes_q.pop_front();
          if (out_payload_byte !== p.data) begin
            $error("payload_byte: expected %h, got %h", p.data, out_payload_byte);
            fail_cnt++;
          end
          if (out_frame_end !== p.last) begin
            $error("frame_end: expected %b, got %b", p.last, out_frame_end);
            fail_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        taken_cnt++;
        deframe_byte(in_rx_byte);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [BYTE_W-1:0] directed[$];
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    out_stall  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // noise, escape then non-start, escape escape start while hunting,
    // frame with extremes and an escaped escape, byte after a close,
    // empty frame, bad escape inside a frame
    directed = '{8'h00, 8'hFF, ESCAPE_RST, 8'h33, ESCAPE_RST, ESCAPE_RST, START_RST,
                 ESCAPE_RST, START_RST, 8'h00, 8'hFF, ESCAPE_RST, ESCAPE_RST,
                 ESCAPE_RST, START_RST, 8'h41, ESCAPE_RST, START_RST, ESCAPE_RST,
                 START_RST, ESCAPE_RST, START_RST, 8'h5A, ESCAPE_RST, 8'h22};
    foreach (directed[i]) send_byte(directed[i]);
    wait_idle();

    // reset codes: full buffer and overflow first, then random frames
    build_frame(FRAME_BYTES);
    build_frame(FRAME_BYTES + 1);
    run_phase(60);
    wait_idle();

    write_reg(REG_ESCAPE, 8'h00);
    write_reg(REG_START, 8'hFF);
    run_phase(35);
    wait_idle();

    // no idling on either side here
    calm = 1'b1;
    write_reg(REG_ESCAPE, 8'hFF);
    write_reg(REG_START, 8'h00);
    run_phase(35);
    wait_idle();
    calm = 1'b0;

    // equal codes
    write_reg(REG_ESCAPE, 8'h55);
    write_reg(REG_START, 8'h55);
    run_phase(35);
    wait_idle();

    write_reg(REG_ESCAPE, BYTE_W'($urandom_range(255)));
    write_reg(REG_START, BYTE_W'($urandom_range(255)));
    run_phase(35);
    wait_idle();

    write_reg(REG_ESCAPE, ESCAPE_RST);
    write_reg(REG_START, START_RST);
    run_phase(25);
    wait_idle();

    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
